// ----- hw/rtl/tvp_pkg.sv -----
// Package for the tile view priority block: formats, constants and the arctangent table.
package tvp_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STEPS    = 30;
    localparam int PIPE_STEPS    = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

    localparam int CW = 64;   // CORDIC x/y width
    localparam int ZW = 36;   // CORDIC angle width, Q.30 radians
    localparam int VW = 60;   // squared distance width
    localparam int DW = 30;   // distance width
    localparam int AW = 32;   // folded angle width
    localparam int BW = 36;   // biased angle width before reduction
    localparam int PW = DW + AW;

    localparam logic [ZW-1:0] PI_Q30     = 36'd3373259426;
    localparam logic [ZW-1:0] TWO_PI_Q30 = 36'd6746518852;
    localparam logic [30:0]   PRIO_MAX   = 31'd1748000000;

    typedef enum logic [1:0] {
        CFG_CAMERA_X = 2'd0,
        CFG_CAMERA_Y = 2'd1,
        CFG_HEADING  = 2'd2
    } t_cfg_idx;

    function automatic logic [ZW-1:0] atan_q30(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
            18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
            21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
            24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
            27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return {{(ZW-32){1'b0}}, v};
    endfunction

endpackage

// ----- hw/rtl/tile_view_priority.sv -----
// Top level of the tile view priority block: offset, CORDIC angle, square root and weighting.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_tile_center_x, i_tile_center_y
//  out     | output    | o_out_valid / i_out_ready  | o_priority_res
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One beat is accepted per cycle while the output is not stalled; the pipeline depth is set
// by the unrolled square-root stages, which outnumber the CORDIC stages that run beside them.
// Reset clears the valid bits and the configuration registers; the data path has no reset.
// A stall on the output freezes every stage together, so nothing is lost or repeated.
module tile_view_priority (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [28:0] i_tile_center_x,
    input  logic [27:0] i_tile_center_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [30:0] o_priority_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [28:0] i_cfg_data
);

    localparam int L = tvp_pkg::PIPE_STEPS;

    logic        en;
    logic [28:0] r_cam_x;
    logic [27:0] r_cam_y;
    logic [19:0] r_heading;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x   <= '0;
            r_cam_y   <= '0;
            r_heading <= '0;
        end else if (i_cfg_valid) begin
            case (tvp_pkg::t_cfg_idx'(i_cfg_index))
                tvp_pkg::CFG_CAMERA_X: r_cam_x   <= i_cfg_data;
                tvp_pkg::CFG_CAMERA_Y: r_cam_y   <= i_cfg_data[27:0];
                tvp_pkg::CFG_HEADING:  r_heading <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stage 0: offsets from the camera.
    logic              r_v0;
    logic signed [29:0] r_dx;
    logic signed [28:0] r_dy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (en)  r_v0 <= i_in_valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx <= $signed({i_tile_center_x[28], i_tile_center_x}) - $signed({r_cam_x[28], r_cam_x});
            r_dy <= $signed({i_tile_center_y[27], i_tile_center_y}) - $signed({r_cam_y[27], r_cam_y});
        end
    end

    // Stage 1: squares and CORDIC pre-rotation into the right half plane.
    logic                          r_v1;
    logic [tvp_pkg::VW-1:0]        r_sqx, r_sqy;
    logic signed [tvp_pkg::CW-1:0] r_c1x, r_c1y;
    logic signed [tvp_pkg::ZW-1:0] r_c1z;
    logic [29:0]                   ux, uy;
    logic signed [tvp_pkg::CW-1:0] x0, y0;

    always_comb begin
        ux = r_dx[29] ? 30'(-r_dx) : 30'(r_dx);
        uy = r_dy[28] ? 30'(-$signed({r_dy[28], r_dy})) : {1'b0, r_dy};
        x0 = {{4{r_dx[29]}}, r_dx, 30'b0};
        y0 = {{5{r_dy[28]}}, r_dy, 30'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en)  r_v1 <= r_v0;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx <= ux * ux;
            r_sqy <= uy * uy;
            if (r_dx[29]) begin
                r_c1x <= -x0;
                r_c1y <= -y0;
                r_c1z <= r_dy[28] ? -$signed(tvp_pkg::PI_Q30) : $signed(tvp_pkg::PI_Q30);
            end else begin
                r_c1x <= x0;
                r_c1y <= y0;
                r_c1z <= '0;
            end
        end
    end

    // Iteration stages: index 0 holds the sum of squares and the pre-rotated vector.
    logic                          r_vs   [0:L];
    logic signed [tvp_pkg::CW-1:0] r_x    [0:L];
    logic signed [tvp_pkg::CW-1:0] r_y    [0:L];
    logic signed [tvp_pkg::ZW-1:0] r_z    [0:L];
    logic [tvp_pkg::VW-1:0]        r_rem  [0:L];
    logic [tvp_pkg::DW-1:0]        r_root [0:L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vs[0] <= 1'b0;
        else if (en)  r_vs[0] <= r_v1;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]    <= r_c1x;
            r_y[0]    <= r_c1y;
            r_z[0]    <= r_c1z;
            r_rem[0]  <= r_sqx + r_sqy;
            r_root[0] <= '0;
        end
    end

    for (genvar j = 0; j < L; j++) begin : g_step
        localparam int B = tvp_pkg::DW - 1 - j;
        logic signed [tvp_pkg::CW-1:0] n_x, n_y;
        logic signed [tvp_pkg::ZW-1:0] n_z;
        logic [tvp_pkg::VW-1:0]        n_rem, trial;
        logic [tvp_pkg::DW-1:0]        n_root;

        always_comb begin
            n_x = r_x[j];
            n_y = r_y[j];
            n_z = r_z[j];
            if (j < tvp_pkg::CORDIC_STAGES) begin
                if (!r_y[j][tvp_pkg::CW-1]) begin
                    n_x = r_x[j] + (r_y[j] >>> j);
                    n_y = r_y[j] - (r_x[j] >>> j);
                    n_z = r_z[j] + $signed(tvp_pkg::atan_q30(j));
                end else begin
                    n_x = r_x[j] - (r_y[j] >>> j);
                    n_y = r_y[j] + (r_x[j] >>> j);
                    n_z = r_z[j] - $signed(tvp_pkg::atan_q30(j));
                end
            end
            n_rem  = r_rem[j];
            n_root = r_root[j];
            trial  = '0;
            if (j < tvp_pkg::SQRT_STEPS) begin
                // Root bits above B are settled, so the trial term is 2*root*2^B + 2^(2B).
                trial = (tvp_pkg::VW'(r_root[j]) << (B + 1)) | (tvp_pkg::VW'(1) << (2 * B));
                if (r_rem[j] >= trial) begin
                    n_rem  = r_rem[j] - trial;
                    n_root = r_root[j] | (tvp_pkg::DW'(1) << B);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vs[j+1] <= 1'b0;
            else if (en)  r_vs[j+1] <= r_vs[j];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x[j+1]    <= n_x;
                r_y[j+1]    <= n_y;
                r_z[j+1]    <= n_z;
                r_rem[j+1]  <= n_rem;
                r_root[j+1] <= n_root;
            end
        end
    end

    // Angle relative to heading, biased by three turns so that it is always positive.
    logic                   r_vm1, r_vm2, r_vm3;
    logic [tvp_pkg::BW-1:0] r_b;
    logic [tvp_pkg::DW-1:0] r_d1, r_d2, r_d3;
    logic signed [37:0]     bsum;

    assign bsum = 38'(r_z[L]) - 38'($signed({r_heading, 14'b0}))
                + $signed({2'b00, tvp_pkg::TWO_PI_Q30} * 38'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
            r_vm2 <= 1'b0;
            r_vm3 <= 1'b0;
        end else if (en) begin
            r_vm1 <= r_vs[L];
            r_vm2 <= r_vm1;
            r_vm3 <= r_vm2;
        end
    end

    // Reduction into one turn and fold into [0, pi].
    logic [tvp_pkg::BW-1:0] amod;
    logic [tvp_pkg::AW-1:0] n_ang, r_ang;
    always_comb begin
        amod = r_b;
        for (int k = 5; k >= 1; k--) begin
            if (r_b >= tvp_pkg::BW'(tvp_pkg::TWO_PI_Q30 * k) && amod == r_b)
                amod = r_b - tvp_pkg::BW'(tvp_pkg::TWO_PI_Q30 * k);
        end
        if (amod > tvp_pkg::PI_Q30) n_ang = tvp_pkg::AW'(tvp_pkg::TWO_PI_Q30 - amod);
        else                        n_ang = tvp_pkg::AW'(amod);
    end

    logic [tvp_pkg::PW-1:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b    <= bsum[tvp_pkg::BW-1:0];
            r_d1   <= r_root[L];
            r_ang  <= n_ang;
            r_d2   <= r_d1;
            r_prod <= r_d2 * r_ang;
            r_d3   <= r_d2;
        end
    end

    // Final sum and saturation into the output register.
    logic [32:0] psum;
    logic        r_out_vld;
    logic [30:0] r_out;
    assign psum = {3'b000, r_d3} + {1'b0, r_prod[tvp_pkg::PW-1:30]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (en)  r_out_vld <= r_vm3;
    end
    always_ff @(posedge i_clk) begin
        if (en) r_out <= (psum > {2'b00, tvp_pkg::PRIO_MAX}) ? tvp_pkg::PRIO_MAX : psum[30:0];
    end

    assign o_out_valid    = r_out_vld;
    assign o_priority_res = r_out;

endmodule
